// File: hdl/bfs_level_nodes_defines.svh
// Assertion macros used by bfs_level_nodes.
`ifndef BFS_LEVEL_NODES_DEFINES_SVH
`define BFS_LEVEL_NODES_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define BFS_ASSERT_IMP(label, clk, rstn, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
    else $error("assertion failed");
// Implication whose consequent is checked at the next clock edge.
`define BFS_ASSERT_NEXT(label, clk, rstn, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

// File: hdl/bfs_pkg.sv
`timescale 1ns / 1ps
package bfs_pkg;
  localparam int unsigned NodeW = 5;
  localparam int unsigned DegW  = 6;

  typedef enum logic [0:0] {
    FUNC_ADD = 1'b0,
    FUNC_RUN = 1'b1
  } func_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD_RD,
    ST_ADD_WA,
    ST_ADD_WB,
    ST_CLR,
    ST_POP,
    ST_POP_WAIT,
    ST_SCAN_RD,
    ST_SCAN_WAIT,
    ST_SCAN_CHK,
    ST_STK_RD,
    ST_STK_OUT
  } state_e;

  // Result beat handed from the sequencer to the output register.
  typedef struct packed {
    logic             valid;
    logic [NodeW-1:0] node;
    logic             phase;
    logic             last;
  } res_t;
endpackage

// File: hdl/bfs_out_reg.sv
`timescale 1ns / 1ps
module bfs_out_reg (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  bfs_pkg::res_t            res_i,
  output logic                     valid_o,
  output logic [bfs_pkg::NodeW-1:0] node_o,
  output logic                     phase_o,
  output logic                     last_o
);
  import bfs_pkg::*;

  res_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
    end else begin
      res_q <= res_i;
    end
  end

  assign valid_o = res_q.valid;
  assign node_o  = res_q.node;
  assign phase_o = res_q.phase;
  assign last_o  = res_q.last & res_q.valid;
endmodule

// File: hdl/bfs_level_nodes.sv
`timescale 1ns / 1ps
// Breadth-first search over an undirected graph kept in on-chip memory.
// Input channel: an item is taken at a clock edge where start is high and
// busy is low. func_i = 0 adds the edge node_a_i - node_b_i; func_i = 1
// runs a search from node_a_i and lists the nodes at depth target_level_i.
// Result channel: each beat is on node_o, phase_o and last_o for exactly one
// cycle while valid_o is high. The receiver cannot stall.
// A run first lists every reached node in visit order (phase 0), then the
// nodes at the target level, most recently found first (phase 1). last_o
// marks the final beat. A run from a node at or above NODES gives no beat.
// An add with both nodes below NODES keeps busy high through a degree check,
// then one adjacency write per endpoint, or through the check alone when the
// edge is dropped; no new command is taken until busy falls. A run clears
// the visit marks, then pops each reached node and reads, waits for and
// checks each of its adjacency entries in turn, then reads out the level
// stack. The first beat, the source's, leaves once the source's list has
// been scanned. The adjacency memory, with one port, paces the scan.
// Reset clears degrees and control; adjacency contents stay undefined.
module bfs_level_nodes #(
  parameter int unsigned NODES      = 32,
  parameter int unsigned MAX_DEGREE = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic                      func_i,
  input  logic [bfs_pkg::NodeW-1:0] node_a_i,
  input  logic [bfs_pkg::NodeW-1:0] node_b_i,
  input  logic [bfs_pkg::NodeW-1:0] target_level_i,
  output logic                      valid_o,
  output logic [bfs_pkg::NodeW-1:0] node_o,
  output logic                      phase_o,
  output logic                      last_o
);
  import bfs_pkg::*;
  `include "bfs_level_nodes_defines.svh"

  localparam int unsigned NW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int unsigned SW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
  localparam int unsigned AW = NW + SW;
  localparam int unsigned CW = NW + 1;

  // Adjacency memory, one port, registered read.
  logic [NodeW-1:0] adj_mem [2**AW];
  logic [NodeW-1:0] adj_rd_q;
  logic             adj_we;
  logic [AW-1:0]    adj_addr;
  logic [NodeW-1:0] adj_wd;

  // Per-node memory holding the queue; a second memory holds the stack.
  logic [NodeW-1:0] q_mem [NODES];
  logic [NodeW-1:0] s_mem [NODES];
  logic [NodeW-1:0] q_rd_q, s_rd_q;
  logic [NodeW-1:0] dep_mem [NODES];

  logic [DegW-1:0]  deg_q [NODES];
  logic [NODES-1:0] vis_q;

  state_e st_q, st_d;
  logic [NodeW-1:0] a_q, b_q, lvl_q, par_q, pdep_q;
  logic [CW-1:0]    head_q, tail_q, sp_q, cnt_q;
  logic [DegW-1:0]  idx_q;
  res_t             res;

  logic a_ok, b_ok;
  assign a_ok = 32'(node_a_i) < NODES;
  assign b_ok = 32'(node_b_i) < NODES;

  logic [NW-1:0] a_i, b_i, ch_i;
  assign a_i  = a_q[NW-1:0];
  assign b_i  = b_q[NW-1:0];
  assign ch_i = adj_rd_q[NW-1:0];

  logic room;
  always_comb begin
    if (a_q == b_q) room = 32'(deg_q[a_i]) + 2 <= MAX_DEGREE;
    else room = (32'(deg_q[a_i]) < MAX_DEGREE) && (32'(deg_q[b_i]) < MAX_DEGREE);
  end

  logic ch_new;
  assign ch_new = (32'(adj_rd_q) < NODES) && !vis_q[ch_i] && (32'(tail_q) < NODES);
  logic [NodeW-1:0] ch_dep;
  assign ch_dep = pdep_q + NodeW'(1);

  always_comb begin
    adj_we   = 1'b0;
    adj_addr = {par_q[NW-1:0], idx_q[SW-1:0]};
    adj_wd   = b_q;
    if (st_q == ST_ADD_WA) begin
      adj_we   = 1'b1;
      adj_addr = {a_i, deg_q[a_i][SW-1:0]};
      adj_wd   = b_q;
    end else if (st_q == ST_ADD_WB) begin
      adj_we   = 1'b1;
      adj_addr = {b_i, deg_q[b_i][SW-1:0]};
      adj_wd   = a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adj_we) adj_mem[adj_addr] <= adj_wd;
    adj_rd_q <= adj_mem[adj_addr];
    q_rd_q   <= q_mem[head_q[NW-1:0]];
    s_rd_q   <= s_mem[sp_q[NW-1:0] - NW'(1)];
  end

  always_comb begin
    st_d = st_q;
    res  = '0;
    unique case (st_q)
      ST_IDLE: begin
        if (start) begin
          if (func_i == FUNC_ADD) st_d = (a_ok && b_ok) ? ST_ADD_RD : ST_IDLE;
          else st_d = a_ok ? ST_CLR : ST_IDLE;
        end
      end
      ST_ADD_RD:  st_d = room ? ST_ADD_WA : ST_IDLE;
      ST_ADD_WA:  st_d = ST_ADD_WB;
      ST_ADD_WB:  st_d = ST_IDLE;
      ST_CLR:     st_d = (32'(cnt_q) == NODES - 1) ? ST_POP : ST_CLR;
      ST_POP:     st_d = (head_q < tail_q) ? ST_POP_WAIT
                         : ((sp_q != '0) ? ST_STK_RD : ST_IDLE);
      ST_POP_WAIT: begin
        st_d = ST_SCAN_RD;
      end
      ST_SCAN_RD: begin
        if (idx_q == DegW'(0)) begin
          res.valid = 1'b1;
          res.node  = par_q;
          res.last  = (head_q == tail_q) && (sp_q == '0) && (deg_q[par_q[NW-1:0]] == '0);
        end
        st_d = (idx_q < deg_q[par_q[NW-1:0]] && 32'(idx_q) < MAX_DEGREE)
               ? ST_SCAN_WAIT : ST_POP;
      end
      ST_SCAN_WAIT: st_d = ST_SCAN_CHK;
      ST_SCAN_CHK:  st_d = ST_SCAN_RD;
      ST_STK_RD:    st_d = ST_STK_OUT;
      ST_STK_OUT: begin
        res.valid = 1'b1;
        res.node  = s_rd_q;
        res.phase = 1'b1;
        res.last  = (sp_q == CW'(1));
        st_d = (sp_q == CW'(1)) ? ST_IDLE : ST_STK_RD;
      end
      default: st_d = ST_IDLE;
    endcase
  end

  // A parent's visit beat is held until its scan ends, since only then is it
  // known whether the queue and the level stack are both empty. A parent with
  // no neighbors has its beat released in the cycle it is taken.
  res_t held_q;
  res_t res_fix;
  always_comb begin
    res_fix = res;
    if (st_q == ST_SCAN_RD && idx_q == DegW'(0)) res_fix.valid = 1'b0;
    if (st_q == ST_SCAN_RD &&
        !(idx_q < deg_q[par_q[NW-1:0]] && 32'(idx_q) < MAX_DEGREE)) begin
      res_fix       = (idx_q == DegW'(0)) ? res : held_q;
      res_fix.valid = 1'b1;
      res_fix.last  = (head_q == tail_q) && (sp_q == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_IDLE;
      vis_q  <= '0;
      head_q <= '0;
      tail_q <= '0;
      sp_q   <= '0;
      cnt_q  <= '0;
      idx_q  <= '0;
      for (int n = 0; n < NODES; n++) deg_q[n] <= '0;
    end else begin
      st_q <= st_d;
      unique case (st_q)
        ST_IDLE: begin
          cnt_q <= '0;
        end
        ST_ADD_WA: deg_q[a_i] <= deg_q[a_i] + DegW'(1);
        ST_ADD_WB: deg_q[b_i] <= deg_q[b_i] + DegW'(1);
        ST_CLR: begin
          cnt_q <= cnt_q + CW'(1);
          if (32'(cnt_q) == NODES - 1) begin
            vis_q        <= NODES'(1) << a_i;
            head_q       <= '0;
            tail_q       <= CW'(1);
            sp_q         <= (lvl_q == '0) ? CW'(1) : '0;
          end else begin
            vis_q[cnt_q[NW-1:0]] <= 1'b0;
          end
        end
        ST_POP: idx_q <= '0;
        ST_POP_WAIT: head_q <= head_q + CW'(1);
        ST_SCAN_CHK: begin
          idx_q <= idx_q + DegW'(1);
          if (ch_new) begin
            vis_q[ch_i] <= 1'b1;
            tail_q      <= tail_q + CW'(1);
            if (ch_dep == lvl_q && 32'(sp_q) < NODES) sp_q <= sp_q + CW'(1);
          end
        end
        ST_STK_OUT: sp_q <= sp_q - CW'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == ST_IDLE && start) begin
      a_q   <= node_a_i;
      b_q   <= node_b_i;
      lvl_q <= target_level_i;
    end
    if (st_q == ST_CLR && 32'(cnt_q) == NODES - 1) begin
      q_mem[0]        <= a_q;
      dep_mem[a_i]    <= '0;
      if (lvl_q == '0) s_mem[0] <= a_q;
    end
    if (st_q == ST_POP_WAIT) begin
      par_q  <= q_rd_q;
      pdep_q <= dep_mem[q_rd_q[NW-1:0]];
    end
    if (st_q == ST_SCAN_RD && idx_q == DegW'(0)) begin
      held_q <= res;
    end
    if (st_q == ST_SCAN_CHK && ch_new) begin
      q_mem[tail_q[NW-1:0]] <= adj_rd_q;
      dep_mem[ch_i]         <= ch_dep;
      if (ch_dep == lvl_q && 32'(sp_q) < NODES) s_mem[sp_q[NW-1:0]] <= adj_rd_q;
    end
  end

  assign busy = (st_q != ST_IDLE);

  bfs_out_reg u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .res_i   (res_fix),
    .valid_o (valid_o),
    .node_o  (node_o),
    .phase_o (phase_o),
    .last_o  (last_o)
  );

  `BFS_ASSERT_IMP(a_tail_bound, clk_i, rst_ni, 1'b1, 32'(tail_q) <= NODES)
  `BFS_ASSERT_IMP(a_head_tail, clk_i, rst_ni, st_q != ST_CLR, head_q <= tail_q)
  `BFS_ASSERT_NEXT(a_add_len, clk_i, rst_ni, st_q == ST_ADD_WA, st_q == ST_ADD_WB)
endmodule

// File: test/bfs_level_nodes_tb.sv
`timescale 1ns / 1ps
// Checks bfs_level_nodes against a behavioral graph search kept in the
// scoreboard. Each add that fits updates the scoreboard's own copy of the
// adjacency lists; every search command queues the beats that the block must
// return. Each beat seen on valid_o is compared with the oldest queued one.

// One expected or observed result beat.
typedef struct {
  logic [bfs_pkg::NodeW-1:0] node;
  logic                      phase;
  logic                      last;
} beat_t;

class bfs_scoreboard;
  localparam int Nodes  = 32;
  localparam int MaxDeg = 32;

  int    adj_list[Nodes][MaxDeg];
  int    deg[Nodes];
  beat_t pending[$];
  int    errors;

  function new();
    foreach (deg[i]) deg[i] = 0;
    errors = 0;
  endfunction

  // Update the graph for an add, or queue the beats of a search.
  function void note_command(bfs_pkg::func_e func, int a, int b, int lvl);
    bit    seen[Nodes];
    int    depth[Nodes];
    int    order[$];
    int    found[$];
    int    head;
    int    par;
    int    ch;
    beat_t bt;
    if (func == bfs_pkg::FUNC_ADD) begin
      // The whole edge is dropped when either list lacks room; a self loop
      // needs two free slots in the same list.
      if (a == b) begin
        if (deg[a] + 2 > MaxDeg) return;
      end else if (deg[a] >= MaxDeg || deg[b] >= MaxDeg) begin
        return;
      end
      adj_list[a][deg[a]] = b;
      deg[a]++;
      adj_list[b][deg[b]] = a;
      deg[b]++;
      return;
    end
    foreach (seen[i]) seen[i] = 0;
    order = {order, a};
    seen[a] = 1;
    depth[a] = 0;
    if (lvl == 0) found = {found, a};
    head = 0;
    while (head < order.size()) begin
      par = order[head];
      head++;
      for (int i = 0; i < deg[par]; i++) begin
        ch = adj_list[par][i];
        if (!seen[ch]) begin
          seen[ch] = 1;
          depth[ch] = (depth[par] + 1) % 32;
          order = {order, ch};
          if (depth[ch] == lvl) found = {found, ch};
        end
      end
    end
    foreach (order[i]) begin
      bt.node = bfs_pkg::NodeW'(order[i]);
      bt.phase = 1'b0;
      bt.last = (i == order.size() - 1) && (found.size() == 0);
      pending = {pending, bt};
    end
    for (int i = found.size() - 1; i >= 0; i--) begin
      bt.node = bfs_pkg::NodeW'(found[i]);
      bt.phase = 1'b1;
      bt.last = (i == 0);
      pending = {pending, bt};
    end
  endfunction

  function void check_beat(beat_t got);
    beat_t want;
    if (pending.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected beat: node %0d phase %0d last %0d",
                 got.node, got.phase, got.last);
      return;
    end
    want = pending.pop_front();
    if (got.node !== want.node || got.phase !== want.phase || got.last !== want.last) begin
      errors++;
      if (errors <= 10)
        $display("beat mismatch: expected node %0d phase %0d last %0d, got %0d %0d %0d",
                 want.node, want.phase, want.last, got.node, got.phase, got.last);
    end
  endfunction
endclass

module bfs_level_nodes_tb;
  import bfs_pkg::*;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic             func_i = 1'b0;
  logic [NodeW-1:0] node_a_i = '0;
  logic [NodeW-1:0] node_b_i = '0;
  logic [NodeW-1:0] target_level_i = '0;
  logic             valid_o;
  logic [NodeW-1:0] node_o;
  logic             phase_o;
  logic             last_o;

  bfs_scoreboard graph_sb = new();
  // When set, the sender never inserts idle cycles between commands.
  bit            no_gaps = 1'b0;

  bfs_level_nodes dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .func_i         (func_i),
    .node_a_i       (node_a_i),
    .node_b_i       (node_b_i),
    .target_level_i (target_level_i),
    .valid_o        (valid_o),
    .node_o         (node_o),
    .phase_o        (phase_o),
    .last_o         (last_o)
  );

  always #5 clk_i = ~clk_i;

  // The receiver cannot stall, so every strobed beat is checked at the edge
  // that closes its cycle.
  always @(posedge clk_i) begin
    beat_t got;
    if (rst_ni && valid_o === 1'b1) begin
      got.node = node_o;
      got.phase = phase_o;
      got.last = last_o;
      graph_sb.check_beat(got);
    end
  end

  // Present one command and hold it until the block takes it. The command is
  // taken at an edge where start is high and busy is low; busy is read
  // right after the edge, before the block's own updates land.
  task automatic send_cmd(func_e func, int a, int b, int lvl);
    if (!no_gaps) begin
      while ($urandom_range(99) < 8) begin
        start <= 1'b0;
        @(posedge clk_i);
      end
    end
    start <= 1'b1;
    func_i <= func;
    node_a_i <= NodeW'(a);
    node_b_i <= NodeW'(b);
    target_level_i <= NodeW'(lvl);
    do @(posedge clk_i); while (busy !== 1'b0);
    graph_sb.note_command(func, a, b, lvl);
  endtask

  // Lower start and hold off until every queued beat has come back.
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk_i);
    while (graph_sb.pending.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    int a;
    int b;
    int lvl;
    int span;
    int base;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: searches on an empty graph, a duplicate edge, the
    // extreme node numbers and levels, and a list filled by self loops.
    send_cmd(FUNC_RUN, 0, 31, 0);
    send_cmd(FUNC_RUN, 31, 0, 31);
    send_cmd(FUNC_ADD, 0, 31, 31);
    send_cmd(FUNC_ADD, 31, 0, 0);
    send_cmd(FUNC_ADD, 0, 1, 7);
    send_cmd(FUNC_RUN, 0, 5, 1);
    send_cmd(FUNC_RUN, 31, 10, 2);
    send_cmd(FUNC_RUN, 1, 10, 9);
    for (int i = 0; i < 17; i++) send_cmd(FUNC_ADD, 5, 5, 0);
    send_cmd(FUNC_ADD, 5, 6, 0);
    send_cmd(FUNC_RUN, 5, 0, 0);
    drain_results();

    // Random part. Adds dominate so the lists grow and some fill up; a
    // narrow node window now and then packs edges onto a few nodes.
    for (int n = 0; n < 450; n++) begin
      no_gaps = (n >= 150 && n < 250);
      if (n == 300) drain_results();
      if (n % 60 == 0) begin
        span = ($urandom_range(2) == 0) ? 4 : 32;
        base = $urandom_range(32 - span);
      end
      a = base + $urandom_range(span - 1);
      b = ($urandom_range(15) == 0) ? a : base + $urandom_range(span - 1);
      lvl = ($urandom_range(1) == 0) ? $urandom_range(4) : $urandom_range(31);
      if ($urandom_range(99) < 22)
        send_cmd(FUNC_RUN, $urandom_range(31), $urandom_range(31), lvl);
      else
        send_cmd(FUNC_ADD, a, b, lvl);
    end

    // Let the last add finish its memory writes, then check the tail.
    start <= 1'b0;
    while (graph_sb.pending.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (graph_sb.errors == 0 && graph_sb.pending.size() == 0)
      $display("bfs_level_nodes verification clean");
    else
      $display("bfs_level_nodes verification failed");
    $finish;
  end

  initial begin
    #50_000_000;
    $display("bfs_level_nodes verification failed");
    $finish;
  end
endmodule

// File: sim.f
+incdir+hdl
hdl/bfs_pkg.sv
hdl/bfs_out_reg.sv
hdl/bfs_level_nodes.sv
test/bfs_level_nodes_tb.sv
